@@ hdl/sha_pkg.sv @@
package sha_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       carries_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } out_item_t;

  // front-to-back block request
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_req_t;

  localparam int unsigned QDepth = 2;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [6:0] NumRounds = 7'd64;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hdl/sha_front.sv @@
module sha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sha_pkg::in_item_t   item_i,
  output logic                full_o,
  output logic                req_valid_o,
  output sha_pkg::blk_req_t   req_o,
  input  logic                req_ready_i
);
  import sha_pkg::*;

  // 0: take items, 1: pad stream, 2: wait to hand off a full block
  localparam logic [1:0] StTake = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [63:0]  len_q, len_d, flen_q, flen_d;
  logic [511:0] blk_q, blk_d;
  logic         fin_q, fin_d;   // a final request is pending in padding
  logic         pad80_q, pad80_d; // 0x80 still to place
  logic         lenph_q, lenph_d; // placing length bytes
  logic         sfin_q, sfin_d;   // block being sent is the last one
  logic         put;
  logic [7:0]   pbyte;
  logic [8:0]   bitpos;

  assign full_o = (state_q != StTake);
  assign req_valid_o = (state_q == StSend);
  assign req_o.block = blk_q;
  assign req_o.final_blk = sfin_q;
  assign bitpos = 9'(10'd511 - {cnt_q, 3'b000});

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; len_d = len_q; flen_d = flen_q;
    blk_d = blk_q; fin_d = fin_q; pad80_d = pad80_q; lenph_d = lenph_q;
    sfin_d = sfin_q; put = 1'b0; pbyte = 8'h00;
    unique case (state_q)
      StTake: begin
        if (push_i) begin
          if (item_i.carries_byte) begin
            put = 1'b1; pbyte = item_i.byte_value;
            len_d = len_q + 64'd8;
          end
          if (item_i.is_final) begin
            fin_d = 1'b1; pad80_d = 1'b1; lenph_d = 1'b0;
            flen_d = item_i.carries_byte ? len_q + 64'd8 : len_q;
            len_d = '0;
          end
        end
      end
      StPad: begin
        put = 1'b1;
        if (pad80_q) begin
          pbyte = PadByte; pad80_d = 1'b0;
          if (cnt_q == 6'(LenPos - 6'd1)) lenph_d = 1'b1;
        end else if (lenph_q) begin
          pbyte = flen_q[{~cnt_q[2:0], 3'b111} -: 8];
        end else begin
          pbyte = 8'h00;
          if (cnt_q == 6'(LenPos - 6'd1)) lenph_d = 1'b1;
        end
      end
      StSend: begin
        if (req_ready_i) begin
          state_d = fin_q ? StPad : StTake;
          if (sfin_q) begin
            state_d = StTake; fin_d = 1'b0; sfin_d = 1'b0;
          end
        end
      end
      default: state_d = StTake;
    endcase
    if (put) begin
      blk_d[bitpos -: 8] = pbyte;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        state_d = StSend;
        sfin_d = fin_d && lenph_d && !pad80_d && (state_q == StPad);
      end else if (state_q == StTake && fin_d) begin
        state_d = StPad;
      end
    end else if (state_q == StTake && fin_d) begin
      state_d = StPad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StTake; cnt_q <= '0; len_q <= '0; fin_q <= 1'b0;
      pad80_q <= 1'b0; lenph_q <= 1'b0; sfin_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; len_q <= len_d; fin_q <= fin_d;
      pad80_q <= pad80_d; lenph_q <= lenph_d; sfin_q <= sfin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    flen_q <= flen_d;
  end

endmodule

@@ hdl/sha_queue.sv @@
module sha_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  sha_pkg::blk_req_t wr_data_i,
  output logic              wr_ready_o,
  output logic              rd_valid_o,
  output sha_pkg::blk_req_t rd_data_o,
  input  logic              rd_ready_i
);
  import sha_pkg::*;

  blk_req_t  mem_q [QDepth];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ hdl/sha_back.sv @@
module sha_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  sha_pkg::blk_req_t req_i,
  output logic              req_ready_o,
  output logic              empty_o,
  input  logic              pop_i,
  output sha_pkg::out_item_t res_o
);
  import sha_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]   state_q;
  logic [5:0]   rnd_q;
  logic [1:0]   part_q;
  logic         fin_q;
  logic [255:0] h_q;
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [31:0]  wt, g0, g1, s0, s1, ch, mj, t1, t2;

  assign req_ready_o = (state_q == StIdle);
  assign empty_o = (state_q != StOut);
  assign res_o.digest_part = h_q[{~part_q, 6'h3f} -: 64];
  assign res_o.part_index = part_q;
  assign res_o.last_part = (part_q == 2'd3);

  always_comb begin
    g0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    g1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = w_q[0];
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + round_k(rnd_q) + wt;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; rnd_q <= '0; part_q <= '0; fin_q <= 1'b0; h_q <= InitH;
    end else begin
      unique case (state_q)
        StIdle: if (req_valid_i) begin
          state_q <= StRun; rnd_q <= '0; fin_q <= req_i.final_blk;
        end
        StRun: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'(NumRounds - 7'd1)) state_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[255 - 32*i -: 32] <= h_q[255 - 32*i -: 32] + v_q[i];
          part_q <= '0;
          state_q <= fin_q ? StOut : StIdle;
        end
        StOut: if (pop_i) begin
          part_q <= part_q + 2'd1;
          if (part_q == 2'd3) begin
            state_q <= StIdle; h_q <= InitH;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // working variables and rolling schedule: w_q[0] is the word of this round
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[255 - 32*i -: 32];
      for (int i = 0; i < 16; i++) w_q[i] <= req_i.block[511 - 32*i -: 32];
    end else if (state_q == StRun) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_q[0] + g0 + w_q[9] + g1;
    end
  end

endmodule

@@ hdl/sha256_stream_hash.sv @@
// SHA-256 stream hasher.
// Input queue side: present a request on item_i and raise push; it is
// taken at a clock edge where push is high and full is low. Each request
// carries at most one message byte; is_final closes the message.
// Result queue side: while empty is low, res_o holds the oldest digest
// part; pop at such an edge takes it. Four parts follow each message,
// most significant first, the fourth flagged by last_part.
// Throughput: one byte per cycle while packing, stalling at block hand-off;
// each 64-byte block is then handed through a two-entry block queue to the
// round engine, which loads it, runs one round per cycle, then one final add.
// The packer stalls at each block hand-off and waits longer only when the
// queue is full. Padding after a final request runs one byte per cycle
// outside those hand-offs. The first part follows once the padding is packed
// and every remaining block has passed the round engine.
// Reset restores the initial hash and empties both sides. A stalled result
// side holds the round engine, which backs the queue and then the packer.
module sha256_stream_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  sha_pkg::in_item_t   item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output sha_pkg::out_item_t  res_o
);
  import sha_pkg::*;

  logic     f_valid, f_ready, b_valid, b_ready;
  blk_req_t f_req, b_req;

  sha_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i, .full_o(full),
    .req_valid_o(f_valid), .req_o(f_req), .req_ready_i(f_ready));

  // hold completed blocks between packer and round engine
  sha_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_data_i(f_req), .wr_ready_o(f_ready),
    .rd_valid_o(b_valid), .rd_data_o(b_req), .rd_ready_i(b_ready));

  sha_back u_back (
    .clk_i, .rst_ni, .req_valid_i(b_valid), .req_i(b_req), .req_ready_o(b_ready),
    .empty_o(empty), .pop_i(pop), .res_o);

endmodule

@@ verif/tb_sha256_stream_hash.sv @@
module tb_sha256_stream_hash;
  import sha_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  in_item_t  item_i;
  logic      full;
  logic      empty;
  logic      pop;
  out_item_t res_o;

  sha256_stream_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .item_i (item_i),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  // Clock and reset: the reset starts low and is then released for good.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Round constants, kept here so the digest model does not lean on the design.
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Message lengths that put the pad byte just before and just at the length field.
  localparam int BoundLen [2] = '{55, 56};

  // Model state of the running message.
  logic [31:0] chain_h [8];
  logic [31:0] blk_w   [16];
  logic [5:0]  fill_cnt;
  logic [63:0] bit_len;

  out_item_t   digest_q [$];
  int          fail_cnt;
  int          part_cnt;
  int          msg_cnt;
  int          sent_cnt;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over the current block and fold into the chain value.
  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endtask

  task automatic pack_byte(logic [7:0] b);
    if (fill_cnt[1:0] == 2'd0) blk_w[fill_cnt[5:2]] = '0;
    blk_w[fill_cnt[5:2]][(3 - fill_cnt[1:0]) * 8 +: 8] = b;
    fill_cnt = fill_cnt + 6'd1;
    if (fill_cnt == 6'd0) compress_blk();
  endtask

  task automatic restart_msg();
    for (int i = 0; i < 8; i++) chain_h[i] = StartH[i];
    fill_cnt = '0;
    bit_len  = '0;
  endtask

  // Absorb one accepted request; on a final request queue the four digest parts.
  task automatic hash_request(in_item_t r);
    logic [63:0] len;
    out_item_t   p;
    if (r.carries_byte) begin
      pack_byte(r.byte_value);
      bit_len += 64'd8;
    end
    if (r.is_final) begin
      len = bit_len;
      pack_byte(PadByte);
      while (fill_cnt != LenPos) pack_byte(8'h00);
      for (int k = 0; k < 8; k++) pack_byte(len[56 - 8 * k +: 8]);
      for (int k = 0; k < 4; k++) begin
        p.digest_part = {chain_h[2 * k], chain_h[2 * k + 1]};
        p.part_index  = 2'(k);
        p.last_part   = (k == 3);
        digest_q.insert(digest_q.size(), p);
      end
      restart_msg();
      msg_cnt++;
    end
  endtask

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_cnt++;
  endtask

  // Result side: random stalls on pop, compare each accepted part.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        part_cnt++;
        if (digest_q.size() == 0) begin
          report($sformatf("unexpected part %h", res_o));
        end else begin
          if (res_o !== digest_q[0])
            report($sformatf("got %h/%0d/%0d exp %h/%0d/%0d",
                   res_o.digest_part, res_o.part_index, res_o.last_part,
                   digest_q[0].digest_part, digest_q[0].part_index,
                   digest_q[0].last_part));
          void'(digest_q.pop_front());
        end
      end
      // Mostly ready, with short random stalls.
      case ($urandom_range(0, 19))
        0, 1, 2: pop <= 1'b0;
        3:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= 1'b1;
      endcase
    end
  end

  // Directed rows: extremes, empty requests, empty message, final with byte.
  typedef struct {
    in_item_t    req;
    logic        chk_top;
    logic [63:0] top_part;
  } dir_row_t;

  dir_row_t dir_tbl [$];
  in_item_t stim_q  [$];

  function automatic in_item_t mk(logic [7:0] b, logic c, logic f);
    in_item_t r;
    r.byte_value = b; r.carries_byte = c; r.is_final = f;
    return r;
  endfunction

  task automatic add_msg(int len, bit rnd);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        stim_q.insert(stim_q.size(), mk(8'($urandom), 1'b0, 1'b0));
      stim_q.insert(stim_q.size(), mk(rnd ? 8'($urandom) : 8'h61 + 8'(i % 3), 1'b1,
                                      (i == len - 1) && $urandom_range(0, 1)));
    end
    if (len == 0 || !stim_q[$].is_final)
      stim_q.insert(stim_q.size(), mk(8'($urandom), 1'b0, 1'b1));
  endtask

  // Drive one request and hold it until the block takes it.
  task automatic send(in_item_t r);
    push   <= 1'b1;
    item_i <= r;
    do @(posedge clk_i); while (full);
    hash_request(r);
    sent_cnt++;
    if ($urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    push     = 1'b0;
    item_i   = '0;
    fail_cnt = 0;
    part_cnt = 0;
    msg_cnt  = 0;
    sent_cnt = 0;
    restart_msg();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    // Empty message straight after reset: digest of the empty string.
    dir_tbl.insert(dir_tbl.size(), '{mk(8'hff, 1'b0, 1'b1), 1'b1, 64'he3b0c44298fc1c14});
    // Empty requests change nothing, then "abc" with the byte on the final request.
    dir_tbl.insert(dir_tbl.size(), '{mk(8'hff, 1'b0, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h61, 1'b1, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h00, 1'b0, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h62, 1'b1, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h63, 1'b1, 1'b1), 1'b1, 64'hba7816bf8f01cfea});
    // Byte extremes.
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h00, 1'b1, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'hff, 1'b1, 1'b0), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h80, 1'b1, 1'b1), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'hff, 1'b1, 1'b1), 1'b0, '0});
    dir_tbl.insert(dir_tbl.size(), '{mk(8'h00, 1'b1, 1'b1), 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send(dir_tbl[i].req);
      // The four newest model parts belong to this row; the design needs far
      // longer than the idle gap to produce them, so they are still queued.
      if (dir_tbl[i].chk_top && dir_tbl[i].req.is_final) begin
        if (digest_q[digest_q.size() - 4].digest_part !== dir_tbl[i].top_part)
          report($sformatf("known digest row %0d model %h", i,
                           digest_q[digest_q.size() - 4].digest_part));
      end
    end

    // Block-boundary lengths, then short random messages.
    for (int i = 0; i < 2; i++) add_msg(BoundLen[i], 1);
    while (stim_q.size() < 190) add_msg($urandom_range(0, 12), 1);
    while (stim_q.size() > 0) send(stim_q.pop_front());
    push <= 1'b0;

    while (digest_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d requests forming %0d messages, checked %0d digest parts.",
             sent_cnt, msg_cnt, part_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #4000000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_queue.sv
hdl/sha_back.sv
hdl/sha256_stream_hash.sv
verif/tb_sha256_stream_hash.sv
